// File: src/ppgs_pkg.sv
// ---------------------------------------------------------------------------
// ppgs_pkg
// shared types and constants for the predator-prey grid step block
// ---------------------------------------------------------------------------
`default_nettype none
package ppgs_pkg;
  localparam int ROWS_MAX = 128;
  localparam int COLS_MAX = 512;
  localparam int RW = $clog2(ROWS_MAX);
  localparam int CW = $clog2(COLS_MAX);
  localparam int AW = RW + CW;
  localparam int NCELLS = ROWS_MAX * COLS_MAX;
  localparam int CNTW = 17;

  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_FISH  = 2'd1;
  localparam logic [1:0] KIND_SHARK = 2'd2;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_ACT   = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  localparam logic [1:0] OUT_NONE   = 2'd0;
  localparam logic [1:0] OUT_STAYED = 2'd1;
  localparam logic [1:0] OUT_MOVED  = 2'd2;
  localparam logic [1:0] OUT_STARVE = 2'd3;

  localparam logic [2:0] REG_ROWS   = 3'd0;
  localparam logic [2:0] REG_COLS   = 3'd1;
  localparam logic [2:0] REG_FBREED = 3'd2;
  localparam logic [2:0] REG_SBREED = 3'd3;
  localparam logic [2:0] REG_STARVE = 3'd4;

  localparam logic [7:0] SAT_MAX = 8'd255;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] breed;
    logic [7:0] hunger;
  } cell_t;
endpackage
`default_nettype wire

// File: src/predator_prey_grid_step_top.sv
// ---------------------------------------------------------------------------
// predator_prey_grid_step_top
// toroidal fish/shark grid with host-ordered act requests
// ---------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  request   in         start & !busy           mode,row,col,dir_order,write_*
//  result    out        done (one cycle)        outcome..shark_total
//  config    in         apb psel/penable/pwrite registers 0..4
//
//  an address outside the grid passes S_RD, S_DEC and S_RESP; a read or an idle
//  act adds the readback states S_RBK and S_RBK2, a write or a starving shark
//  also S_WSRC. an act checks up to eight neighbors (fish first for a shark),
//  each through one memory port, and a move then writes two cells.
//  begin tick sweeps the moved flags one entry a cycle. after reset a clearing
//  pass empties the grid while busy stays high. results cannot be stalled.
// ---------------------------------------------------------------------------
`default_nettype none
module predator_prey_grid_step_top
  import ppgs_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [4:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic      [31:0]     prdata,
  output logic                 pready,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic [1:0]      mode,
  input  wire logic [RW-1:0]   row,
  input  wire logic [CW-1:0]   col,
  input  wire logic [7:0]      dir_order,
  input  wire logic [1:0]      write_kind,
  input  wire logic [7:0]      write_breed,
  input  wire logic [7:0]      write_hunger,
  output logic                 done,
  output logic [1:0]           outcome,
  output logic                 ate_fish,
  output logic                 left_baby,
  output logic [RW-1:0]        dest_row,
  output logic [CW-1:0]        dest_col,
  output logic [1:0]           read_kind,
  output logic [7:0]           read_breed,
  output logic [7:0]           read_hunger,
  output logic [CNTW-1:0]      fish_total,
  output logic [CNTW-1:0]      shark_total
);
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_NADR  = 4'd4;
  localparam logic [3:0] S_NCHK  = 4'd5;
  localparam logic [3:0] S_WDST  = 4'd6;
  localparam logic [3:0] S_WSRC  = 4'd7;
  localparam logic [3:0] S_RBK   = 4'd8;
  localparam logic [3:0] S_RBK2  = 4'd9;
  localparam logic [3:0] S_TICK  = 4'd10;
  localparam logic [3:0] S_RESP  = 4'd11;

  logic [3:0] state;
  logic [AW-1:0] sweep;

  logic [7:0] grid_rows, shark_breed_age, fish_breed_age, shark_starve_limit;
  logic [9:0] grid_cols;

  cell_t cell_mem [NCELLS];
  logic  moved_mem [NCELLS];
  cell_t rd_cell;
  logic  rd_moved;
  logic [AW-1:0] mem_addr;
  logic          mem_we, moved_we, moved_wd;
  cell_t         mem_wd;

  logic [1:0]    rq_mode;
  logic [RW-1:0] rq_row, nr, ndr;
  logic [CW-1:0] rq_col, nc, ndc;
  logic [7:0]    rq_order;
  cell_t         rq_wr, src;
  logic          in_grid;
  logic [1:0]    k;
  logic          want_fish;
  logic          ate, baby;
  logic [1:0]    res;
  logic [CNTW-1:0] fish_count, shark_count;

  logic [RW:0] rows;
  logic [CW:0] cols;

  // config extents
  always_comb begin
    if (grid_rows == 8'd0) rows = (RW+1)'(1);
    else if (32'(grid_rows) > ROWS_MAX) rows = (RW+1)'(ROWS_MAX);
    else rows = (RW+1)'(grid_rows);
    if (grid_cols == 10'd0) cols = (CW+1)'(1);
    else if (32'(grid_cols) > COLS_MAX) cols = (CW+1)'(COLS_MAX);
    else cols = (CW+1)'(grid_cols);
  end

  assign pready = 1'b1;
  always_comb begin
    case (paddr[4:2])
      REG_ROWS:   prdata = {24'd0, grid_rows};
      REG_COLS:   prdata = {22'd0, grid_cols};
      REG_FBREED: prdata = {24'd0, fish_breed_age};
      REG_SBREED: prdata = {24'd0, shark_breed_age};
      REG_STARVE: prdata = {24'd0, shark_starve_limit};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= 8'd128; grid_cols <= 10'd512; fish_breed_age <= 8'd3;
      shark_breed_age <= 8'd10; shark_starve_limit <= 8'd4;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_ROWS:   grid_rows <= pwdata[7:0];
        REG_COLS:   grid_cols <= pwdata[9:0];
        REG_FBREED: fish_breed_age <= pwdata[7:0];
        REG_SBREED: shark_breed_age <= pwdata[7:0];
        REG_STARVE: shark_starve_limit <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // single port memories
  always_ff @(posedge clk) begin
    if (mem_we) cell_mem[mem_addr] <= mem_wd;
    rd_cell <= cell_mem[mem_addr];
  end
  always_ff @(posedge clk) begin
    if (moved_we) moved_mem[mem_addr] <= moved_wd;
    rd_moved <= moved_mem[mem_addr];
  end

  // neighbor of the request cell in direction k of the order
  logic [1:0] dir;
  always_comb begin
    dir = rq_order[2*k +: 2];
    ndr = rq_row;
    ndc = rq_col;
    case (dir)
      2'd0: ndr = (rq_row == '0) ? RW'(rows - 1'b1) : rq_row - 1'b1;
      2'd2: ndr = ((RW+1)'(rq_row) + 1'b1 >= rows) ? '0 : rq_row + 1'b1;
      2'd1: ndc = ((CW+1)'(rq_col) + 1'b1 >= cols) ? '0 : rq_col + 1'b1;
      default: ndc = (rq_col == '0) ? CW'(cols - 1'b1) : rq_col - 1'b1;
    endcase
  end

  // aged counters of the cell just read
  logic [7:0] br_inc, hu_inc;
  assign br_inc = (rd_cell.breed < SAT_MAX) ? rd_cell.breed + 8'd1 : rd_cell.breed;
  assign hu_inc = (rd_cell.kind == KIND_SHARK && rd_cell.hunger < SAT_MAX) ?
                  rd_cell.hunger + 8'd1 : rd_cell.hunger;

  logic breeds;
  logic [7:0] age, new_h;
  assign age    = (src.kind == KIND_FISH) ? fish_breed_age : shark_breed_age;
  assign breeds = src.breed >= age;
  assign new_h  = (src.kind == KIND_FISH || ate) ? 8'd0 : src.hunger;

  function automatic logic [CNTW-1:0] adj(logic [CNTW-1:0] v, logic [1:0] ok,
                                          logic [1:0] nk, logic [1:0] kk);
    logic [CNTW-1:0] t;
    t = v;
    if (ok == kk) t = t - 1'b1;
    if (nk == kk) t = t + 1'b1;
    return t;
  endfunction

  logic [AW-1:0] src_addr, nb_addr, dst_addr;
  assign src_addr = {rq_row, rq_col};
  assign nb_addr  = {ndr, ndc};
  assign dst_addr = {nr, nc};

  always_comb begin
    mem_addr = src_addr;
    mem_we   = 1'b0;
    mem_wd   = rq_wr;
    moved_we = 1'b0;
    moved_wd = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_addr = sweep; mem_we = 1'b1; mem_wd = '0; moved_we = 1'b1;
      end
      S_TICK: begin
        mem_addr = sweep; moved_we = 1'b1;
      end
      S_NADR: mem_addr = nb_addr;
      S_WDST: begin
        mem_addr = dst_addr; mem_we = 1'b1;
        mem_wd = '{src.kind, breeds ? 8'd0 : src.breed, new_h};
        moved_we = 1'b1; moved_wd = 1'b1;
      end
      S_WSRC: begin
        mem_we = 1'b1;
        if (res == OUT_MOVED) mem_wd = breeds ? '{src.kind, 8'd0, new_h} : '0;
        else if (res == OUT_STARVE) mem_wd = '0;
        else mem_wd = src;
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      state <= S_CLEAR; sweep <= '0; fish_count <= '0; shark_count <= '0;
    end else begin
      done <= (state == S_RESP);
      case (state)
        S_CLEAR, S_TICK: begin
          sweep <= sweep + 1'b1;
          if (&sweep) begin
            state <= (state == S_CLEAR) ? S_IDLE : S_RBK;
          end
        end
        S_IDLE: if (start) begin
          rq_mode <= mode; rq_row <= row; rq_col <= col; rq_order <= dir_order;
          rq_wr <= '{(write_kind == 2'd3) ? KIND_EMPTY : write_kind,
                     write_breed, write_hunger};
          in_grid <= ((RW+1)'(row) < rows) && ((CW+1)'(col) < cols);
          nr <= row; nc <= col; ate <= 1'b0; baby <= 1'b0; res <= OUT_NONE;
          sweep <= '0;
          state <= (mode == MODE_TICK) ? S_TICK : S_RD;
        end
        S_RD: state <= S_DEC;
        S_DEC: begin
          if (!in_grid) state <= S_RESP;
          else if (rq_mode == MODE_WRITE) begin
            fish_count  <= adj(fish_count, rd_cell.kind, rq_wr.kind, KIND_FISH);
            shark_count <= adj(shark_count, rd_cell.kind, rq_wr.kind, KIND_SHARK);
            src <= rq_wr;
            state <= S_WSRC;
          end else if (rq_mode == MODE_ACT && !rd_moved &&
                       rd_cell.kind != KIND_EMPTY) begin
            src <= '{rd_cell.kind, br_inc, hu_inc};
            if (rd_cell.kind == KIND_SHARK && hu_inc >= shark_starve_limit) begin
              res <= OUT_STARVE;
              shark_count <= shark_count - 1'b1;
              state <= S_WSRC;
            end else state <= S_NADR;
            want_fish <= (rd_cell.kind == KIND_SHARK);
            k <= 2'd0;
          end else state <= S_RBK;
        end
        S_NADR: state <= S_NCHK;
        S_NCHK: begin
          if (rd_cell.kind == (want_fish ? KIND_FISH : KIND_EMPTY) &&
              nb_addr != src_addr) begin
            nr <= ndr; nc <= ndc; ate <= want_fish; res <= OUT_MOVED;
            state <= S_WDST;
          end else if (k != 2'd3) begin
            k <= k + 1'b1; state <= S_NADR;
          end else if (want_fish) begin
            want_fish <= 1'b0; k <= 2'd0; state <= S_NADR;
          end else begin
            res <= OUT_STAYED; state <= S_WSRC;
          end
        end
        S_WDST: begin
          baby <= breeds;
          if (src.kind == KIND_FISH) begin
            if (breeds) fish_count <= fish_count + 1'b1;
          end else begin
            if (ate) fish_count <= fish_count - 1'b1;
            if (breeds) shark_count <= shark_count + 1'b1;
          end
          state <= S_WSRC;
        end
        S_WSRC: state <= S_RBK;
        S_RBK: state <= S_RBK2;
        // readback of the cell after the step
        S_RBK2: begin
          if (in_grid) src <= rd_cell;
          state <= S_RESP;
        end
        S_RESP: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    outcome     = res;
    ate_fish    = ate;
    left_baby   = baby;
    dest_row    = nr;
    dest_col    = nc;
    read_kind   = in_grid ? src.kind : KIND_EMPTY;
    read_breed  = in_grid ? src.breed : 8'd0;
    read_hunger = in_grid ? src.hunger : 8'd0;
    fish_total  = fish_count;
    shark_total = shark_count;
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while busy");
  a_moved_dest: assert property (@(posedge clk) disable iff (rst)
    (done && outcome == OUT_MOVED) |-> !(dest_row == rq_row && dest_col == rq_col))
    else $error("move onto own cell");
endmodule
`default_nettype wire
